/* rtl/core/sbfd_pkg.sv */
// Package for the frame decoder: register indexes, reset values, widths,
// and the structs passed between the front end, the run queue and the back end.
// No dependencies.
package sbfd_pkg;

  localparam int NumCh      = 10;
  localparam int NumAnalog  = 6;
  localparam int ChW        = 11;
  localparam int ValW       = 12;
  localparam int SlotW      = 4;
  localparam int PosW       = 5;
  localparam int AccW       = 19;
  localparam int CntW       = 5;
  localparam int IdxW       = 4;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 11;
  localparam int QDepth     = 2;
  localparam int QPtrW      = $clog2(QDepth);
  localparam int QCntW      = $clog2(QDepth + 1);

  localparam logic [PosW-1:0]  PosHeader  = 5'd0;
  localparam logic [PosW-1:0]  PosLastCh  = 5'd14;
  localparam logic [PosW-1:0]  PosStatus  = 5'd23;
  localparam logic [PosW-1:0]  PosFooter  = 5'd24;
  localparam logic [PosW-1:0]  PosParked  = 5'd25;
  localparam logic [CntW-1:0]  BitsPerByte = 5'd8;
  localparam logic [CntW-1:0]  BitsPerCh   = 5'd11;
  localparam logic [SlotW-1:0] LastSlot    = SlotW'(NumCh - 1);
  localparam logic [SlotW-1:0] FirstSwitch = SlotW'(NumAnalog);

  localparam logic [7:0]     HeaderRst    = 8'd15;
  localparam logic [7:0]     FooterRst    = 8'd0;
  localparam logic [ChW-1:0] OffsetRst    = 11'd1024;
  localparam logic [ChW-1:0] ThresholdRst = 11'd400;
  localparam logic [7:0]     ReloadRst    = 8'hFA;
  localparam logic [7:0]     LostMaskRst  = 8'd4;
  localparam logic [7:0]     FsMaskRst    = 8'd8;
  localparam logic [7:0]     OnlineRst    = 8'hFA;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER    = 3'd0,
    CFG_FOOTER    = 3'd1,
    CFG_OFFSET    = 3'd2,
    CFG_THRESHOLD = 3'd3,
    CFG_RELOAD    = 3'd4,
    CFG_LOST_MASK = 3'd5,
    CFG_FS_MASK   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]     header_value;
    logic [7:0]     footer_value;
    logic [ChW-1:0] center_offset;
    logic [ChW-1:0] switch_threshold;
    logic [7:0]     timeout_reload;
    logic [7:0]     lost_mask;
    logic [7:0]     failsafe_mask;
  } cfg_t;

  // one pending run of results
  typedef struct packed {
    logic [NumCh-1:0][ChW-1:0] chans;
    logic                      frame_drop;
    logic                      failsafe;
    logic                      lost;
  } run_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

/* rtl/core/sbfd_front.sv */
// Front end: accepts bytes and ticks, checks framing, unpacks channels,
// runs the online counter and pushes finished runs into the queue.
// Depends on sbfd_pkg.
module sbfd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                action,
  input  logic [7:0]          data_byte,
  input  logic                frame_start,
  input  sbfd_pkg::cfg_t      cfg,
  output logic                push,
  output sbfd_pkg::run_t      push_data
);
  import sbfd_pkg::*;

  logic [PosW-1:0]    pos;
  logic               header_ok;
  logic [AccW-1:0]    acc;
  logic [CntW-1:0]    cnt;
  logic [IdxW-1:0]    ch_idx;
  logic [ChW-1:0]     chans [NumCh];
  logic [7:0]         status_byte;
  logic [7:0]         online_count;

  logic [PosW-1:0]    p;
  logic [AccW-1:0]    acc_sum;
  logic [CntW-1:0]    cnt_sum;
  logic               frame_ok;
  logic               tick_out;
  logic               byte_in;

  assign byte_in  = accept && !action;
  assign p        = frame_start ? PosHeader : pos;
  assign acc_sum  = acc | (AccW'(data_byte) << cnt);
  assign cnt_sum  = cnt + BitsPerByte;
  assign frame_ok = byte_in && (p == PosFooter) && header_ok &&
                    (data_byte == cfg.footer_value);
  assign tick_out = accept && action && (online_count == '0);
  assign push     = frame_ok || tick_out;

  always_comb begin
    for (int k = 0; k < NumCh; k++) begin
      push_data.chans[k] = chans[k];
    end
    push_data.lost       = tick_out;
    push_data.frame_drop = !tick_out && ((status_byte & cfg.lost_mask) != '0);
    push_data.failsafe   = !tick_out && ((status_byte & cfg.failsafe_mask) != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= PosParked;
      header_ok    <= 1'b0;
      acc          <= '0;
      cnt          <= '0;
      ch_idx       <= '0;
      online_count <= OnlineRst;
    end else begin
      if (accept && action && online_count != '0) begin
        online_count <= online_count - 8'd1;
      end
      if (byte_in) begin
        if (frame_start) begin
          acc    <= '0;
          cnt    <= '0;
          ch_idx <= '0;
        end
        if (p == PosHeader) begin
          header_ok <= (data_byte == cfg.header_value);
          pos       <= p + PosW'(1);
        end else if (p <= PosLastCh) begin
          if (cnt_sum >= BitsPerCh) begin
            acc    <= acc_sum >> ChW;
            cnt    <= cnt_sum - BitsPerCh;
            ch_idx <= ch_idx + IdxW'(1);
          end else begin
            acc <= acc_sum;
            cnt <= cnt_sum;
          end
          pos <= p + PosW'(1);
        end else if (p == PosFooter) begin
          pos <= PosParked;
          if (frame_ok) begin
            online_count <= cfg.timeout_reload;
          end
        end else if (p < PosParked) begin
          pos <= p + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in && p != PosHeader && p <= PosLastCh && cnt_sum >= BitsPerCh &&
        ch_idx < IdxW'(NumCh)) begin
      chans[ch_idx] <= acc_sum[ChW-1:0];
    end
    if (byte_in && p == PosStatus) begin
      status_byte <= data_byte;
    end
  end

endmodule

/* rtl/core/sbfd_queue.sv */
// Short run queue between front end and back end.
// Depends on sbfd_pkg.
module sbfd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sbfd_pkg::run_t       push_data,
  input  logic                 pop,
  output sbfd_pkg::run_t       head,
  output sbfd_pkg::q_status_t  stat
);
  import sbfd_pkg::*;

  run_t             mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign head       = mem[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == QCntW'(QDepth));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QDepth - 1)) ? '0 : wr_ptr + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QDepth - 1)) ? '0 : rd_ptr + QPtrW'(1);
      end
      if (push && !pop) begin
        count <= count + QCntW'(1);
      end else if (pop && !push) begin
        count <= count - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/core/sbfd_back.sv */
// Back end: walks the head run slot by slot, centres and classifies channels,
// and drives the registered result channel.
// Depends on sbfd_pkg.
module sbfd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  sbfd_pkg::run_t             head,
  input  logic                       empty,
  input  sbfd_pkg::cfg_t             cfg,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sbfd_pkg::SlotW-1:0] slot,
  output logic signed [sbfd_pkg::ValW-1:0] value,
  output logic                       frame_drop,
  output logic                       failsafe,
  output logic                       link_lost,
  output logic                       last
);
  import sbfd_pkg::*;

  logic [SlotW-1:0]       slot_cnt;
  logic                   load;
  logic                   fire;
  logic signed [ValW-1:0] centred;
  logic signed [ValW-1:0] thr;
  logic signed [ValW-1:0] val_next;

  assign load    = !out_valid || out_ready;
  assign fire    = load && !empty;
  assign pop     = fire && (slot_cnt == LastSlot);
  assign centred = $signed({1'b0, head.chans[slot_cnt]}) -
                   $signed({1'b0, cfg.center_offset});
  assign thr     = $signed({1'b0, cfg.switch_threshold});

  always_comb begin
    if (head.lost) begin
      val_next = '0;
    end else if (slot_cnt < FirstSwitch) begin
      val_next = centred;
    end else if (centred > thr) begin
      val_next = ValW'(1);
    end else if (centred < -thr) begin
      val_next = '1;
    end else begin
      val_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_cnt  <= '0;
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
      slot_cnt  <= (slot_cnt == LastSlot) ? '0 : slot_cnt + SlotW'(1);
    end else if (load) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      slot       <= slot_cnt;
      value      <= val_next;
      frame_drop <= head.frame_drop;
      failsafe   <= head.failsafe;
      link_lost  <= head.lost;
      last       <= (slot_cnt == LastSlot);
    end
  end

endmodule

/* rtl/core/sbus_frame_decoder.sv */
// SBUS frame decoder top level: configuration registers, front end,
// run queue and back end. Depends on sbfd_pkg, sbfd_front, sbfd_queue, sbfd_back.
//
// Input channel (in_valid/in_ready): one transfer per received byte
// (action = 0, frame_start marks byte 0) or per monitor tick (action = 1).
// One item is taken every cycle while the run queue has room; in_ready
// drops while the queue holds two runs, the one going out counting until its last slot fires.
// Output channel (out_valid/out_ready): a run of ten results, slots 0..9,
// last set on slot 9. A good footer byte or a tick at timeout queues a run;
// its first result can be taken once the run has passed the queue and then the output register, and
// the run then goes out one result per cycle while out_ready is high, paced by the back end.
// A receiver stall holds the output register and the back end; the front
// end keeps taking bytes until the queue fills.
// Configuration (cfg_valid/cfg_ready): cfg_ready is always high; write
// only while the block is idle. Index 7 is ignored.
// Reset (rst, synchronous): registers return to their defaults, the decoder
// parks until a frame start, the online counter reloads to 250, queue empties.
module sbus_frame_decoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic [7:0]                        data_byte,
  input  logic                              frame_start,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sbfd_pkg::SlotW-1:0]        slot,
  output logic signed [sbfd_pkg::ValW-1:0]  value,
  output logic                              frame_drop,
  output logic                              failsafe,
  output logic                              link_lost,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbfd_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [sbfd_pkg::CfgDataW-1:0]     cfg_data
);
  import sbfd_pkg::*;

  cfg_t      cfg;
  run_t      push_data;
  run_t      head;
  q_status_t q_stat;
  logic      push;
  logic      pop;
  logic      in_xfer;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_stat.full;
  assign in_xfer   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_value     <= HeaderRst;
      cfg.footer_value     <= FooterRst;
      cfg.center_offset    <= OffsetRst;
      cfg.switch_threshold <= ThresholdRst;
      cfg.timeout_reload   <= ReloadRst;
      cfg.lost_mask        <= LostMaskRst;
      cfg.failsafe_mask    <= FsMaskRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEADER:    cfg.header_value     <= cfg_data[7:0];
        CFG_FOOTER:    cfg.footer_value     <= cfg_data[7:0];
        CFG_OFFSET:    cfg.center_offset    <= cfg_data[ChW-1:0];
        CFG_THRESHOLD: cfg.switch_threshold <= cfg_data[ChW-1:0];
        CFG_RELOAD:    cfg.timeout_reload   <= cfg_data[7:0];
        CFG_LOST_MASK: cfg.lost_mask        <= cfg_data[7:0];
        CFG_FS_MASK:   cfg.failsafe_mask    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  sbfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_xfer),
    .action      (action),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .cfg         (cfg),
    .push        (push),
    .push_data   (push_data)
  );

  sbfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  sbfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (q_stat.empty),
    .cfg        (cfg),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .slot       (slot),
    .value      (value),
    .frame_drop (frame_drop),
    .failsafe   (failsafe),
    .link_lost  (link_lost),
    .last       (last)
  );

`ifndef SYNTHESIS
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && slot == $past(slot) + SlotW'(1))
    else $error("run broken between slots");

  a_lost_zeroed: assert property (@(posedge clk) disable iff (rst)
    out_valid && link_lost |-> value == '0 && !frame_drop && !failsafe)
    else $error("link-lost result not zeroed");

  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (slot == LastSlot)))
    else $error("last flag out of step with slot");
`endif

endmodule
